/* rtl/csl_pkg.sv */
// csl_pkg: shared types for the comment and literal stripper
// holds the queue entry passed from the classifier front to the output back
// no dependencies
`default_nettype none

package csl_pkg;

  // one classified input beat: up to two kept bytes plus end-of-text marker
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;    // byte1 follows byte0
    logic       kept;   // byte0 is a kept byte (clear only on a bare end marker)
    logic       fin;    // closes the text
  } entry_t;

endpackage

`default_nettype wire

/* rtl/csl_fifo.sv */
// csl_fifo: short flop queue of csl_pkg::entry_t between front and back
// depends on csl_pkg
`default_nettype none

module csl_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire csl_pkg::entry_t wr_data,
  input  wire logic            pop,
  output csl_pkg::entry_t      rd_data,
  output logic                 full,
  output logic                 not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  csl_pkg::entry_t store_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/csl_front.sv */
// csl_front: accepts text bytes, tracks comment/literal mode, classifies each beat
// produces csl_pkg::entry_t for the queue; depends on csl_pkg
`default_nettype none

module csl_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] b,
  input  wire logic       fin,
  output logic            push,
  output csl_pkg::entry_t entry
);

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_LINE   = 5'b00010,
    MODE_BLOCK  = 5'b00100,
    MODE_STRING = 5'b01000,
    MODE_CHAR   = 5'b10000
  } mode_t;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BS    = 8'h5c;

  mode_t      mode_r, mode_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       skip_held_r, skip_held_nxt;
  logic       parity_r, parity_nxt;

  logic [7:0] em0, em1;
  logic [1:0] cnt;
  logic       normal_go;
  logic       quote_ok;

  assign quote_ok = !parity_r;

  always_comb begin
    mode_nxt       = mode_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    skip_held_nxt  = skip_held_r;
    em0            = '0;
    em1            = '0;
    cnt            = '0;
    normal_go      = 1'b0;

    case (mode_r)
      MODE_LINE: begin
        if (b == CH_NL) begin
          mode_nxt = MODE_NORMAL;
          em0      = b;
          cnt      = 2'd1;
        end
      end
      MODE_BLOCK: begin
        if (held_valid_r && b == CH_SLASH) begin
          mode_nxt       = MODE_NORMAL;
          held_valid_nxt = 1'b0;
          held_byte_nxt  = '0;
          skip_held_nxt  = 1'b0;
        end else if (b == CH_STAR) begin
          held_byte_nxt  = b;
          held_valid_nxt = 1'b1;
          skip_held_nxt  = 1'b1;
        end else begin
          held_valid_nxt = 1'b0;
          held_byte_nxt  = '0;
          skip_held_nxt  = 1'b0;
        end
      end
      MODE_STRING: begin
        if (b == CH_DQ && quote_ok) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_CHAR: begin
        if (b == CH_SQ && quote_ok) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (held_valid_r) begin
          held_valid_nxt = 1'b0;
          held_byte_nxt  = '0;
          skip_held_nxt  = 1'b0;
          if (b == CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (b == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end else begin
            // held slash was plain division, emit it first
            em0       = CH_SLASH;
            cnt       = 2'd1;
            normal_go = 1'b1;
          end
        end else begin
          normal_go = 1'b1;
        end
      end
    endcase

    if (normal_go) begin
      if (b == CH_SLASH) begin
        held_byte_nxt  = b;
        held_valid_nxt = 1'b1;
        skip_held_nxt  = 1'b0;
      end else if (b == CH_DQ && quote_ok) begin
        mode_nxt = MODE_STRING;
      end else if (b == CH_SQ && quote_ok) begin
        mode_nxt = MODE_CHAR;
      end else begin
        if (cnt == 2'd0) begin
          em0 = b;
        end else begin
          em1 = b;
        end
        cnt = cnt + 2'd1;
      end
    end

    parity_nxt = (b == CH_BS) ? !parity_r : 1'b0;

    if (fin) begin
      // flush a held slash; a held star in a block comment is dropped
      if (held_valid_nxt && !skip_held_nxt && cnt != 2'd2) begin
        if (cnt == 2'd0) begin
          em0 = held_byte_nxt;
        end else begin
          em1 = held_byte_nxt;
        end
        cnt = cnt + 2'd1;
      end
      mode_nxt       = MODE_NORMAL;
      held_byte_nxt  = '0;
      held_valid_nxt = 1'b0;
      skip_held_nxt  = 1'b0;
      parity_nxt     = 1'b0;
    end
  end

  assign push        = acc && ((cnt != 2'd0) || fin);
  assign entry.byte0 = em0;
  assign entry.byte1 = em1;
  assign entry.two   = (cnt == 2'd2);
  assign entry.kept  = (cnt != 2'd0);
  assign entry.fin   = fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_NORMAL;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      skip_held_r  <= 1'b0;
      parity_r     <= 1'b0;
    end else if (acc) begin
      mode_r       <= mode_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      skip_held_r  <= skip_held_nxt;
      parity_r     <= parity_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/csl_back.sv */
// csl_back: pops queue entries and serialises them into result beats
// owns the output register; depends on csl_pkg
`default_nettype none

module csl_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire csl_pkg::entry_t head,
  input  wire logic            head_avail,
  output logic                 pop,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output logic [7:0]           res_byte,
  output logic                 res_kept,
  output logic                 res_done,
  output logic                 res_last
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       kept_r, done_r, last_r;
  logic       pend_r, pend_nxt;
  logic [7:0] pend_byte_r;
  logic       pend_fin_r;
  logic       slot_free;
  logic       load;

  assign slot_free = !vld_r || res_ready;
  assign pop       = slot_free && !pend_r && head_avail;
  assign load      = slot_free && (pend_r || head_avail);

  always_comb begin
    pend_nxt = pend_r;
    if (slot_free) begin
      if (pend_r) begin
        pend_nxt = 1'b0;
      end else if (head_avail) begin
        pend_nxt = head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (slot_free) begin
        vld_r <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_r) begin
        byte_r <= pend_byte_r;
        kept_r <= 1'b1;
        done_r <= pend_fin_r;
        last_r <= 1'b1;
      end else if (head_avail) begin
        byte_r      <= head.byte0;
        kept_r      <= head.kept;
        done_r      <= head.fin && !head.two;
        last_r      <= !head.two;
        pend_byte_r <= head.byte1;
        pend_fin_r  <= head.fin;
      end
    end
  end

  assign res_valid = vld_r;
  assign res_byte  = byte_r;
  assign res_kept  = kept_r;
  assign res_done  = done_r;
  assign res_last  = last_r;

endmodule

`default_nettype wire

/* rtl/comment_and_literal_stripper.sv */
// comment_and_literal_stripper: top level, strips C/C++ comments and literals
// instantiates csl_front, csl_fifo and csl_back; depends on csl_pkg
`default_nettype none

//  channel  handshake                    payload
//  -------  ---------------------------  ----------------------------------------
//  input    in_valid / in_ready          in_byte[7:0], in_is_final
//  result   out_item_valid / out_ready   out_byte[7:0], out_valid, out_text_done,
//                                        out_run_end
//
//  one input beat is accepted per cycle while the queue has room; a beat
//  that yields one result leaves at one per cycle while out_ready is high;
//  a beat that yields two results (held slash plus a following byte) holds
//  the output register for each result in turn, so the output register sets the sustained rate
//  an accepted beat passes through the queue, then the output register
//  reset is synchronous, active low; it clears mode, held byte and queue
//  a stalled result side fills the queue and then drops in_ready

module comment_and_literal_stripper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_is_final,
  output logic            out_item_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            out_text_done,
  output logic            out_run_end
);

  csl_pkg::entry_t front_entry;
  csl_pkg::entry_t head_entry;
  logic            front_push;
  logic            q_full;
  logic            q_not_empty;
  logic            back_pop;
  logic            in_acc;

  // the front only stalls when the queue cannot take another beat
  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  // front: mode tracking, lookahead on slash and star, quote parity
  csl_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .b     (in_byte),
    .fin   (in_is_final),
    .push  (front_push),
    .entry (front_entry)
  );

  // decoupling queue, beats that yield nothing and do not end the text are never pushed
  csl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .wr_data   (front_entry),
    .pop       (back_pop),
    .rd_data   (head_entry),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // back: splits two-byte entries and drives the result beat
  csl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_entry),
    .head_avail (q_not_empty),
    .pop        (back_pop),
    .res_valid  (out_item_valid),
    .res_ready  (out_ready),
    .res_byte   (out_byte),
    .res_kept   (out_valid),
    .res_done   (out_text_done),
    .res_last   (out_run_end)
  );

endmodule

`default_nettype wire

/* dv/comment_and_literal_stripper_tb.sv */
// comment_and_literal_stripper_tb: self-checking bench for the comment and literal stripper
// drives byte texts through the valid/ready input, predicts every result beat, checks them in order
// depends on rtl/comment_and_literal_stripper.sv (and csl_pkg through it)
`timescale 1ns / 100ps

module comment_and_literal_stripper_tb;

  // scanner modes of the stripper, mirrored here for prediction
  typedef enum logic [2:0] {
    SCAN_NORMAL,
    SCAN_LINE_COMMENT,
    SCAN_BLOCK_COMMENT,
    SCAN_STRING,
    SCAN_CHAR
  } scan_mode_t;

  // one beat on the result channel
  typedef struct packed {
    logic [7:0] text_byte;
    logic       kept;
    logic       done;
    logic       last_of_beat;
  } strip_beat_t;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 340;

  localparam string IDENT_POOL = "abcxyz019_ ";
  localparam string BODY_POOL  = "ab */\\\"'\n*/";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_is_final = 1'b0;
  logic       out_item_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_text_done;
  logic       out_run_end;

  comment_and_literal_stripper DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_is_final   (in_is_final),
    .out_item_valid(out_item_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .out_text_done (out_text_done),
    .out_run_end   (out_run_end)
  );

  // idling rates in percent of cycles, changed per test phase
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 58;
  logic        recv_hold = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // predictor state, a private copy of the scanner
  scan_mode_t  scan_mode = SCAN_NORMAL;
  logic [7:0]  held_char = 8'h00;
  logic        held_live = 1'b0;
  logic        held_in_comment = 1'b0;
  logic        backslash_odd = 1'b0;

  strip_beat_t stripped_beats[$];
  logic [7:0]  text_buf[$];

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk = ~clk;
  end

  // a hung handshake ends the run here rather than hanging the simulator
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // scanner prediction: one accepted byte gives zero, one or two result beats
  // ---------------------------------------------------------------------------
  function void drop_held();
    held_live = 1'b0;
    held_char = 8'h00;
    held_in_comment = 1'b0;
  endfunction

  function void add_beat(input logic [7:0] c, input logic kept, input logic done,
                         input logic last);
    strip_beat_t bt;
    bt = {c, kept, done, last};
    stripped_beats.insert(stripped_beats.size(), bt);
  endfunction

  function void add_char(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function void predict_beat(input logic [7:0] b, input logic fin);
    logic [7:0] kept_chars[2];
    int         n_kept;
    logic       quote_ok;
    logic       plain;
    n_kept = 0;
    kept_chars[0] = 8'h00;
    kept_chars[1] = 8'h00;
    quote_ok = !backslash_odd;
    plain = 1'b0;

    case (scan_mode)
      SCAN_LINE_COMMENT: begin
        // the newline ends the comment but is itself kept
        if (b == CH_NL) begin
          scan_mode = SCAN_NORMAL;
          kept_chars[0] = b;
          n_kept = 1;
        end
      end
      SCAN_BLOCK_COMMENT: begin
        if (held_live && b == CH_SLASH) begin
          scan_mode = SCAN_NORMAL;
          drop_held();
        end else if (b == CH_STAR) begin
          held_char = b;
          held_live = 1'b1;
          held_in_comment = 1'b1;
        end else begin
          drop_held();
        end
      end
      SCAN_STRING: begin
        if (b == CH_DQUOTE && quote_ok) scan_mode = SCAN_NORMAL;
      end
      SCAN_CHAR: begin
        if (b == CH_SQUOTE && quote_ok) scan_mode = SCAN_NORMAL;
      end
      default: begin
        scan_mode = SCAN_NORMAL;
        plain = 1'b1;
        if (held_live) begin
          // a held slash is resolved by the byte after it
          drop_held();
          if (b == CH_SLASH) begin
            scan_mode = SCAN_LINE_COMMENT;
            plain = 1'b0;
          end else if (b == CH_STAR) begin
            scan_mode = SCAN_BLOCK_COMMENT;
            plain = 1'b0;
          end else begin
            kept_chars[0] = CH_SLASH;
            n_kept = 1;
          end
        end
        if (plain) begin
          if (b == CH_SLASH) begin
            held_char = b;
            held_live = 1'b1;
            held_in_comment = 1'b0;
          end else if (b == CH_DQUOTE && quote_ok) begin
            scan_mode = SCAN_STRING;
          end else if (b == CH_SQUOTE && quote_ok) begin
            scan_mode = SCAN_CHAR;
          end else begin
            kept_chars[n_kept] = b;
            n_kept++;
          end
        end
      end
    endcase

    // backslash run parity is tracked in every mode
    backslash_odd = (b == CH_BSLASH) ? !backslash_odd : 1'b0;

    if (fin) begin
      // flush a pending slash; a star pending in a block comment is lost
      if (held_live && !held_in_comment && n_kept < 2) begin
        kept_chars[n_kept] = held_char;
        n_kept++;
      end
      scan_mode = SCAN_NORMAL;
      drop_held();
      backslash_odd = 1'b0;
      if (n_kept == 0) add_beat(8'h00, 1'b0, 1'b1, 1'b1);
    end

    for (int k = 0; k < n_kept; k++) begin
      add_beat(kept_chars[k], 1'b1, fin && (k == n_kept - 1), k == n_kept - 1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one byte per call, entered and left right after a rising edge
  // ---------------------------------------------------------------------------
  task send_beat(input logic [7:0] b, input logic fin);
    logic took;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    in_is_final <= fin;
    // in_ready is stable from the falling edge to the next rising edge
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    predict_beat(b, fin);
  endtask

  task send_text(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], fin_last && (i == s.len() - 1));
    end
  endtask

  function logic [7:0] pick_char(input string pool);
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  // appends one C-like token to the text buffer, sometimes a broken one
  function void append_fragment();
    int unsigned kind;
    kind = $urandom_range(11);
    case (kind)
      0: add_char(8'($urandom_range(255)));
      1, 2: begin
        repeat ($urandom_range(1, 5)) add_char(pick_char(IDENT_POOL));
      end
      3: begin
        add_char(CH_SLASH);
        add_char(CH_SLASH);
        repeat ($urandom_range(4)) add_char(pick_char(BODY_POOL));
        if ($urandom_range(4) != 0) add_char(CH_NL);
      end
      4: begin
        add_char(CH_SLASH);
        add_char(CH_STAR);
        repeat ($urandom_range(5)) add_char(pick_char(BODY_POOL));
        if ($urandom_range(5) != 0) begin
          add_char(CH_STAR);
          add_char(CH_SLASH);
        end
      end
      5: begin
        add_char(CH_DQUOTE);
        repeat ($urandom_range(5)) begin
          if ($urandom_range(2) == 0) add_char(CH_BSLASH);
          add_char(pick_char(BODY_POOL));
        end
        if ($urandom_range(5) != 0) add_char(CH_DQUOTE);
      end
      6: begin
        add_char(CH_SQUOTE);
        if ($urandom_range(1) == 0) add_char(CH_BSLASH);
        add_char(pick_char(BODY_POOL));
        add_char(CH_SQUOTE);
      end
      7: add_char(pick_char("/*\\\"'"));
      8: add_char(pick_char(" \n\t"));
      default: begin
        // division and multiplication between operands
        add_char(pick_char(IDENT_POOL));
        add_char($urandom_range(1) ? CH_SLASH : CH_STAR);
        add_char(pick_char(IDENT_POOL));
      end
    endcase
  endfunction

  // whole texts of random tokens, each closed by a final byte
  task send_random_texts(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      text_buf.delete();
      repeat ($urandom_range(1, 6)) append_fragment();
      foreach (text_buf[i]) send_beat(text_buf[i], i == text_buf.size() - 1);
      sent += text_buf.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random ready, with an optional long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // sampled at the falling edge, where everything driven at the rising edge has settled
  always @(negedge clk) begin
    strip_beat_t got;
    strip_beat_t want;
    if (rst_n && out_item_valid && out_ready) begin
      got = '{out_byte, out_valid, out_text_done, out_run_end};
      if (stripped_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result beat: byte %02h valid %0b done %0b end %0b",
                   got.text_byte, got.kept, got.done, got.last_of_beat);
      end else begin
        want = stripped_beats.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: exp byte/valid/done/end %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                     want.text_byte, want.kept, want.done, want.last_of_beat,
                     got.text_byte, got.kept, got.done, got.last_of_beat);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked texts for the corner cases of the scanner
  task test_directed_cases();
    // lone slash as the whole text: flushed by the final flag
    send_beat(CH_SLASH, 1'b1);
    // line comment swallows 8'hFF, keeps the newline, then 8'h00 ends the text
    send_text("//", 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(CH_NL, 1'b0);
    send_beat(8'h00, 1'b1);
    // the opener star must not pair with the following slash
    send_text("/*/*/q", 1'b1);
    // escaped quote inside a string
    send_text("\"\\\"\"k", 1'b1);
    // double backslash in a char literal, nothing kept: bare end marker
    send_text("'\\\\'", 1'b1);
    // star pending in a block comment at the end is dropped
    send_text("/**", 1'b1);
    // held slash released by a quote that opens a string
    send_text("/\"", 1'b1);
  endtask

  task test_random_busy_receiver();
    send_idle_pct = 34;
    recv_idle_pct = 58;
    send_random_texts(PHASE_ITEMS);
  endtask

  task test_random_busy_sender();
    send_idle_pct = 58;
    recv_idle_pct = 34;
    send_random_texts(PHASE_ITEMS);
  endtask

  // receiver holds off long enough that the internal queue fills and in_ready drops
  task test_output_backpressure();
    send_idle_pct = 0;
    fork
      begin
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join_none
    send_random_texts(30);
  endtask

  task test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_texts(PHASE_ITEMS);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed_cases();
    test_random_busy_receiver();
    test_random_busy_sender();
    test_output_backpressure();
    test_random_full_rate();

    in_valid <= 1'b0;
    while (stripped_beats.size() != 0) @(posedge clk);
    // catch any stray beats after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && stripped_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
